>>> rtl/pbst_pkg.sv
// Shared types, field layout and control store of the push-button session tracker.
// Depends on nothing; imported by the tracker, its port checker and the testbench.
package pbst_pkg;

   localparam int MAC_W      = 48;
   localparam int UUID_W     = 64;
   localparam int STAMP_W    = 32;
   localparam int WINDOW_W   = 16;
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = STAMP_W + MAC_W + 2 * UUID_W;
   localparam int RSP_DATA_W = MAC_W + 2 * UUID_W;

   localparam int NOW_LSB    = 0;
   localparam int MAC_LSB    = NOW_LSB + STAMP_W;
   localparam int UHI_LSB    = MAC_LSB + MAC_W;
   localparam int ULO_LSB    = UHI_LSB + UUID_W;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd120;

   typedef enum logic [KIND_W-1:0] {
      KIND_NOTE   = 2'd0,
      KIND_QUERY  = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      OVL_NONE  = 2'd0,
      OVL_ONE   = 2'd1,
      OVL_MULTI = 2'd2
   } status_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [UUID_W-1:0]  uuid_lo;
      logic [UUID_W-1:0]  uuid_hi;
      logic [MAC_W-1:0]   mac;
   } entry_type;

   // Sequencer steps (control store addresses)
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LIST_INIT,
      ST_LIST_PRIME,
      ST_LIST_SCAN,
      ST_LIST_END,
      ST_QUERY_INIT,
      ST_QUERY_PRIME,
      ST_QUERY_FIRST,
      ST_QUERY_SECOND,
      ST_QUERY_OUT,
      ST_CLEAR
   } step_type;

   typedef enum logic [3:0] {
      A_NONE,
      A_INIT,
      A_ADVANCE,
      A_SCAN,
      A_COMMIT,
      A_Q_FIRST,
      A_Q_SECOND,
      A_Q_OUT,
      A_CLEAR
   } act_type;

   // Jump taken when the condition holds; otherwise the step repeats.
   typedef enum logic [1:0] {
      C_ALWAYS,
      C_DISPATCH,
      C_SCAN_END,
      C_OUT_FREE
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type target;
   } ucode_type;

   function automatic ucode_type ucode_rom(step_type s);
      ucode_type w;
      case (s)
         ST_IDLE:         w = '{A_NONE,     C_DISPATCH, ST_IDLE};
         ST_LIST_INIT:    w = '{A_INIT,     C_ALWAYS,   ST_LIST_PRIME};
         ST_LIST_PRIME:   w = '{A_ADVANCE,  C_ALWAYS,   ST_LIST_SCAN};
         ST_LIST_SCAN:    w = '{A_SCAN,     C_SCAN_END, ST_LIST_END};
         ST_LIST_END:     w = '{A_COMMIT,   C_ALWAYS,   ST_IDLE};
         ST_QUERY_INIT:   w = '{A_INIT,     C_ALWAYS,   ST_QUERY_PRIME};
         ST_QUERY_PRIME:  w = '{A_ADVANCE,  C_ALWAYS,   ST_QUERY_FIRST};
         ST_QUERY_FIRST:  w = '{A_Q_FIRST,  C_ALWAYS,   ST_QUERY_SECOND};
         ST_QUERY_SECOND: w = '{A_Q_SECOND, C_ALWAYS,   ST_QUERY_OUT};
         ST_QUERY_OUT:    w = '{A_Q_OUT,    C_OUT_FREE, ST_IDLE};
         ST_CLEAR:        w = '{A_CLEAR,    C_ALWAYS,   ST_IDLE};
         default:         w = '{A_NONE,     C_ALWAYS,   ST_IDLE};
      endcase
      return w;
   endfunction

   function automatic step_type dispatch(kind_type k);
      step_type s;
      case (k)
         KIND_NOTE:   s = ST_LIST_INIT;
         KIND_REMOVE: s = ST_LIST_INIT;
         KIND_QUERY:  s = ST_QUERY_INIT;
         KIND_CLEAR:  s = ST_CLEAR;
         default:     s = ST_IDLE;
      endcase
      return s;
   endfunction

endpackage

>>> rtl/push_button_session_tracker.sv
// Push-button session tracker: microcoded sequencer over a recency-ordered entry memory.
// Depends on pbst_pkg (field layout, step/action codes, control store).
//
// Usage:
//   req_* carries one item per transfer: kind in req_tuser, the request fields in
//   req_tdata. Note and remove items update the table; clear empties it; a query
//   gives one transfer on rsp_* with overlap_status in rsp_tuser and the newest
//   live entry in rsp_tdata. csr_* writes walk_window and is always ready.
//   The table is a circular memory of MAX_ENTRIES words (head pointer plus count),
//   walked one entry per cycle through its registered read port.
//   Steps, from the accept cycle back to req_tready:
//     note / remove: init, prime, scan, end - the scan
//       of the memory reads and compacts one entry per cycle.
//     query: init, prime, first, second, out; the result is loaded into the output register in out;
//     clear: the clear step alone.
//   Reset empties the table at once (count cleared, no memory pass) and sets
//   walk_window to 120. A stalled result stays in the output register while
//   the next item is taken; a following query waits for that register to drain.
module push_button_session_tracker #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // now_seconds, station_mac, uuid_high, uuid_low
   input  logic [pbst_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [pbst_pkg::KIND_W-1:0]     req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // found_mac, found_uuid_high, found_uuid_low
   output logic [pbst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // overlap_status
   output logic [pbst_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pbst_pkg::WINDOW_W-1:0]   csr_data
);
   import pbst_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = $clog2(MAX_ENTRIES + 2);
   localparam int SW = IW + 1;
   localparam logic [SW-1:0] DEPTH_S  = SW'(MAX_ENTRIES);
   localparam logic [AW-1:0] LAST_A   = AW'(MAX_ENTRIES - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(MAX_ENTRIES);
   localparam logic [CW-1:0] DEPTH_C1 = CW'(MAX_ENTRIES - 1);

   entry_type entry_mem [MAX_ENTRIES];

   step_type                step_ff, step_in;
   kind_type                kind_ff;
   logic [STAMP_W-1:0]      now_ff;
   logic [MAC_W-1:0]        mac_ff;
   logic [UUID_W-1:0]       uhi_ff, ulo_ff;
   logic [WINDOW_W-1:0]     window_ff;
   logic [AW-1:0]           head_ff, head_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [IW-1:0]           i_ff, i_in;
   logic [CW-1:0]           w_ff, w_in;
   logic                    matched_ff, matched_in;
   logic                    live0_ff, live0_in;
   entry_type               rd_q_ff;
   logic [RSP_DATA_W-1:0]   found_ff, found_in;
   status_type              status_ff, status_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   status_type              rsp_status_ff;

   ucode_type               ctrl;
   logic                    req_acc, is_note, out_free, rsp_load;
   logic [STAMP_W-1:0]      limit_sum;
   logic                    stale, key_hit, skip, entry_ok, scan_end;
   logic [CW-1:0]           w_limit;
   logic [SW-1:0]           rd_sum, rd_wrap, wr_sum, wr_wrap;
   logic                    rd_ok;
   logic [AW-1:0]           head_dec;
   logic                    mem_we;
   logic [AW-1:0]           mem_waddr;
   entry_type               mem_wdata;

   assign ctrl       = ucode_rom(step_ff);
   assign req_tready = (step_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign is_note    = (kind_ff == KIND_NOTE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Entry under evaluation sits in rd_q_ff and has index i_ff - 1.
   assign limit_sum = rd_q_ff.stamp + STAMP_W'(window_ff);
   assign stale     = now_ff > limit_sum;
   assign key_hit   = (rd_q_ff.mac == mac_ff) &&
                      (!is_note || ((rd_q_ff.uuid_hi == uhi_ff) && (rd_q_ff.uuid_lo == ulo_ff)));
   assign skip      = key_hit && !matched_ff;
   assign entry_ok  = i_ff <= IW'(cnt_ff);
   assign w_limit   = is_note ? DEPTH_C1 : DEPTH_C;
   assign scan_end  = !entry_ok || (w_ff == w_limit) || (is_note && stale && !skip);

   // Circular addressing: logical slot k lives at head + k (mod depth)
   assign rd_sum   = SW'(head_ff) + SW'(i_ff);
   assign rd_wrap  = (rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum;
   assign rd_ok    = rd_wrap < DEPTH_S;
   assign wr_sum   = SW'(head_ff) + SW'(w_ff);
   assign wr_wrap  = (wr_sum >= DEPTH_S) ? wr_sum - DEPTH_S : wr_sum;
   assign head_dec = (head_ff == '0) ? LAST_A : head_ff - 1'b1;

   // Next step
   always_comb begin
      case (ctrl.cond)
         C_ALWAYS:   step_in = ctrl.target;
         C_DISPATCH: step_in = req_acc ? dispatch(kind_type'(req_tuser)) : step_ff;
         C_SCAN_END: step_in = scan_end ? ctrl.target : step_ff;
         C_OUT_FREE: step_in = out_free ? ctrl.target : step_ff;
         default:    step_in = ST_IDLE;
      endcase
   end

   // Datapath controls decoded from the control word
   always_comb begin
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      i_in       = i_ff;
      w_in       = w_ff;
      matched_in = matched_ff;
      live0_in   = live0_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      rsp_load   = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = wr_wrap[AW-1:0];
      mem_wdata  = rd_q_ff;
      case (ctrl.act)
         A_INIT: begin
            i_in       = '0;
            w_in       = '0;
            matched_in = 1'b0;
         end
         A_ADVANCE: begin
            i_in = i_ff + 1'b1;
         end
         A_SCAN: begin
            // compaction: write slot never passes the slot being read
            if (!scan_end) begin
               i_in = i_ff + 1'b1;
               if (skip) begin
                  matched_in = 1'b1;
               end else begin
                  mem_we = 1'b1;
                  w_in   = w_ff + 1'b1;
               end
            end
         end
         A_COMMIT: begin
            if (is_note) begin
               mem_we    = 1'b1;
               mem_waddr = head_dec;
               mem_wdata = '{stamp: now_ff, uuid_lo: ulo_ff, uuid_hi: uhi_ff, mac: mac_ff};
               head_in   = head_dec;
               cnt_in    = w_ff + 1'b1;
            end else begin
               cnt_in = w_ff;
            end
         end
         A_Q_FIRST: begin
            i_in     = i_ff + 1'b1;
            live0_in = entry_ok && !stale;
            found_in = (entry_ok && !stale) ?
                       {rd_q_ff.uuid_lo, rd_q_ff.uuid_hi, rd_q_ff.mac} : '0;
         end
         A_Q_SECOND: begin
            if (!live0_ff) begin
               status_in = OVL_NONE;
            end else if (entry_ok && !stale) begin
               status_in = OVL_MULTI;
            end else begin
               status_in = OVL_ONE;
            end
         end
         A_Q_OUT: begin
            rsp_load = out_free;
         end
         A_CLEAR: begin
            cnt_in = '0;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         head_ff      <= '0;
         cnt_ff       <= '0;
         i_ff         <= '0;
         w_ff         <= '0;
         matched_ff   <= 1'b0;
         live0_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         i_ff         <= i_in;
         w_ff         <= w_in;
         matched_ff   <= matched_in;
         live0_ff     <= live0_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            window_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      found_ff  <= found_in;
      status_ff <= status_in;
      if (req_acc) begin
         kind_ff <= kind_type'(req_tuser);
         now_ff  <= req_tdata[NOW_LSB +: STAMP_W];
         mac_ff  <= req_tdata[MAC_LSB +: MAC_W];
         uhi_ff  <= req_tdata[UHI_LSB +: UUID_W];
         ulo_ff  <= req_tdata[ULO_LSB +: UUID_W];
      end
      if (rsp_load) begin
         rsp_data_ff   <= found_ff;
         rsp_status_ff <= status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_ok) begin
         rd_q_ff <= entry_mem[rd_wrap[AW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> rtl/pbst_checker.sv
// Port-level checks for the push-button session tracker, bound to its top level.
// Depends on pbst_pkg and on push_button_session_tracker.
module pbst_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pbst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [pbst_pkg::STATUS_W-1:0]   rsp_tuser
);
   import pbst_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // no live entry means zeroed found fields
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == OVL_NONE) |-> (rsp_tdata == '0))
      else $error("found fields not zero for empty query");

   // every item keeps the sequencer busy in the cycle after its transfer
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a transfer");

   // a new result is only loaded at the end of a query, while input is held off
   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while sequencer idle");

endmodule

bind push_button_session_tracker pbst_checker u_pbst_checker (.*);

>>> tb/pbst_checker.sv
// Port checker for the push-button session tracker: predicts overlap reports and compares them.
// Depends on pbst_pkg for field widths and kind/status codes; watches req_*, rsp_* and csr_*.
module pbst_scoreboard #(
   parameter int MAX_ENTRIES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [pbst_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [pbst_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [pbst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [pbst_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [pbst_pkg::WINDOW_W-1:0]   csr_data,
   output int                              errors,
   output int                              pending,
   output int                              items_seen,
   output int                              reports_seen
);
   import pbst_pkg::*;

   typedef struct packed {
      status_type        status;
      logic [MAC_W-1:0]  mac;
      logic [UUID_W-1:0] uuid_hi;
      logic [UUID_W-1:0] uuid_lo;
   } overlap_report_type;

   // Recency-ordered table, slot 0 newest; slots below live_n are valid.
   logic [MAC_W-1:0]    slot_mac   [MAX_ENTRIES];
   logic [UUID_W-1:0]   slot_uhi   [MAX_ENTRIES];
   logic [UUID_W-1:0]   slot_ulo   [MAX_ENTRIES];
   logic [STAMP_W-1:0]  slot_stamp [MAX_ENTRIES];
   int                  live_n;
   logic [WINDOW_W-1:0] walk_window;

   overlap_report_type reports_due [$];

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      errors++;
      $display("mismatch on %s at %0t: got %h, want %h", field, $realtime, got, want);
   endtask

   // Sum wraps at 32 bits, compare unsigned.
   function automatic bit slot_expired(input logic [STAMP_W-1:0] now_s, input int i);
      logic [STAMP_W-1:0] limit;
      limit = slot_stamp[i] + {{(STAMP_W-WINDOW_W){1'b0}}, walk_window};
      return now_s > limit;
   endfunction

   task automatic drop_slot(input int i);
      int k;
      if (i < 0 || i >= live_n)
         return;
      for (k = i; k + 1 < live_n; k++) begin
         slot_mac[k]   = slot_mac[k+1];
         slot_uhi[k]   = slot_uhi[k+1];
         slot_ulo[k]   = slot_ulo[k+1];
         slot_stamp[k] = slot_stamp[k+1];
      end
      live_n--;
   endtask

   task automatic note_probe(input logic [STAMP_W-1:0] now_s, input logic [MAC_W-1:0] m,
                             input logic [UUID_W-1:0] h, input logic [UUID_W-1:0] l);
      int i;
      for (i = 0; i < live_n; i++) begin
         if (slot_mac[i] == m && slot_uhi[i] == h && slot_ulo[i] == l) begin
            drop_slot(i);
            break;
         end
      end
      if (live_n >= MAX_ENTRIES)
         drop_slot(live_n - 1);
      for (i = live_n; i > 0; i--) begin
         slot_mac[i]   = slot_mac[i-1];
         slot_uhi[i]   = slot_uhi[i-1];
         slot_ulo[i]   = slot_ulo[i-1];
         slot_stamp[i] = slot_stamp[i-1];
      end
      slot_mac[0]   = m;
      slot_uhi[0]   = h;
      slot_ulo[0]   = l;
      slot_stamp[0] = now_s;
      live_n++;
      // the fresh front entry is never aged out
      for (i = 1; i < live_n; i++) begin
         if (slot_expired(now_s, i)) begin
            live_n = i;
            break;
         end
      end
   endtask

   function automatic overlap_report_type predict_overlap(input logic [STAMP_W-1:0] now_s);
      overlap_report_type r;
      int i;
      int cnt;
      r.status  = OVL_NONE;
      r.mac     = '0;
      r.uuid_hi = '0;
      r.uuid_lo = '0;
      cnt = 0;
      for (i = 0; i < live_n; i++) begin
         if (slot_expired(now_s, i))
            break;
         cnt++;
         if (cnt > 1)
            break;
         r.mac     = slot_mac[i];
         r.uuid_hi = slot_uhi[i];
         r.uuid_lo = slot_ulo[i];
      end
      r.status = (cnt > 1) ? OVL_MULTI : (cnt == 1) ? OVL_ONE : OVL_NONE;
      return r;
   endfunction

   task automatic remove_station(input logic [MAC_W-1:0] m);
      int i;
      for (i = 0; i < live_n; i++) begin
         if (slot_mac[i] == m) begin
            drop_slot(i);
            break;
         end
      end
   endtask

   initial begin
      errors       = 0;
      pending      = 0;
      items_seen   = 0;
      reports_seen = 0;
      live_n       = 0;
      walk_window  = WINDOW_RESET;
   end

   always @(posedge clock) begin
      overlap_report_type want;
      logic [STAMP_W-1:0] t;
      logic [MAC_W-1:0]   m;
      logic [UUID_W-1:0]  h;
      logic [UUID_W-1:0]  l;
      if (reset) begin
         live_n      = 0;
         walk_window = WINDOW_RESET;
         reports_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            reports_seen++;
            if (reports_due.size() == 0) begin
               report_mismatch("result with none due", 64'(rsp_tdata[MAC_W-1:0]), 64'd0);
            end else begin
               want = reports_due.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("overlap_status", 64'(rsp_tuser), 64'(want.status));
               if (rsp_tdata[MAC_W-1:0] !== want.mac)
                  report_mismatch("found_mac", 64'(rsp_tdata[MAC_W-1:0]), 64'(want.mac));
               if (rsp_tdata[MAC_W +: UUID_W] !== want.uuid_hi)
                  report_mismatch("found_uuid_high", rsp_tdata[MAC_W +: UUID_W], want.uuid_hi);
               if (rsp_tdata[MAC_W+UUID_W +: UUID_W] !== want.uuid_lo)
                  report_mismatch("found_uuid_low", rsp_tdata[MAC_W+UUID_W +: UUID_W],
                                  want.uuid_lo);
            end
         end
         if (csr_valid && csr_ready)
            walk_window = csr_data;
         if (req_tvalid && req_tready) begin
            items_seen++;
            t = req_tdata[NOW_LSB +: STAMP_W];
            m = req_tdata[MAC_LSB +: MAC_W];
            h = req_tdata[UHI_LSB +: UUID_W];
            l = req_tdata[ULO_LSB +: UUID_W];
            case (kind_type'(req_tuser))
               KIND_NOTE:   note_probe(t, m, h, l);
               KIND_QUERY:  reports_due.push_back(predict_overlap(t));
               KIND_REMOVE: remove_station(m);
               KIND_CLEAR:  live_n = 0;
               default:     live_n = live_n;
            endcase
         end
      end
      pending = reports_due.size();
   end

endmodule

>>> tb/tb_top.sv
// Testbench top for the push-button session tracker: clock, reset, stimulus and verdict.
// Depends on pbst_pkg, push_button_session_tracker and pbst_scoreboard.
module tb_top;
   import pbst_pkg::*;

   localparam int MAX_ENTRIES  = 16;
   localparam int DRAIN_CYCLES = MAX_ENTRIES + 12;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 210;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [WINDOW_W-1:0]   csr_data = '0;

   int errors;
   int pending;
   int items_seen;
   int reports_seen;

   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          quiet     = 0;
   int          windows_used = 1;
   logic [31:0] now_t = '0;

   int phase_window [PHASES] = '{0, 65535, 120, 1, 3000, 65535, 40, -1};
   int phase_pool   [PHASES] = '{4, 24, 8, 3, 12, 20, 6, 10};

   push_button_session_tracker #(.MAX_ENTRIES(MAX_ENTRIES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   pbst_scoreboard #(.MAX_ENTRIES(MAX_ENTRIES)) u_scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .errors       (errors),
      .pending      (pending),
      .items_seen   (items_seen),
      .reports_seen (reports_seen)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);

   // Watchdog: cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Starts and ends at a falling edge; leaves tvalid high for the caller to lower.
   task automatic send_item(input kind_type k, input logic [31:0] t, input logic [47:0] m,
                            input logic [63:0] h, input logic [63:0] l);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {l, h, m, t};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic set_window(input logic [WINDOW_W-1:0] w);
      while (pending != 0)
         @(negedge clock);
      // a note or remove may still be compacting the table
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= w;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_items();
      logic [47:0] ones48;
      logic [63:0] ones64;
      ones48 = '1;
      ones64 = '1;
      send_item(KIND_QUERY,  32'd0,   48'd0,  64'd0,  64'd0);   // empty table
      send_item(KIND_NOTE,   32'd100, ones48, ones64, ones64);
      send_item(KIND_QUERY,  32'd100, 48'd0,  64'd0,  64'd0);
      send_item(KIND_NOTE,   32'd150, 48'd0,  64'd0,  64'd0);
      send_item(KIND_QUERY,  32'd150, ones48, ones64, ones64);  // overlap
      send_item(KIND_QUERY,  32'd221, 48'd0,  64'd0,  64'd0);   // older one aged out
      send_item(KIND_QUERY,  32'd271, 48'd0,  64'd0,  64'd0);   // front aged out
      send_item(KIND_NOTE,   32'd200, ones48, ones64, ones64);  // same station re-noted
      send_item(KIND_NOTE,   32'd210, ones48, 64'h5, ones64);   // same address, other uuid
      send_item(KIND_QUERY,  32'd210, 48'd0,  64'd0,  64'd0);
      send_item(KIND_REMOVE, 32'd210, ones48, 64'd0,  64'd0);
      send_item(KIND_QUERY,  32'd210, 48'd0,  64'd0,  64'd0);
      send_item(KIND_REMOVE, 32'd210, 48'h123456, 64'd0, 64'd0);  // matches nothing
      send_item(KIND_QUERY,  32'd210, 48'd0,  64'd0,  64'd0);
      send_item(KIND_NOTE,   32'd400, 48'hA5A5_5A5A_0F0F, 64'h1, 64'h2);  // ages out the rest
      send_item(KIND_QUERY,  32'd400, 48'd0,  64'd0,  64'd0);
      send_item(KIND_CLEAR,  32'd400, 48'd0,  64'd0,  64'd0);
      send_item(KIND_QUERY,  32'd400, 48'd0,  64'd0,  64'd0);
      // time stamps near the top: stamp plus window wraps past zero
      send_item(KIND_NOTE,   32'hFFFF_FFF0, 48'h1, 64'h3, 64'h4);
      send_item(KIND_QUERY,  32'd5,         48'd0, 64'd0, 64'd0);
      send_item(KIND_QUERY,  32'hFFFF_FFF5, 48'd0, 64'd0, 64'd0);
      send_item(KIND_NOTE,   32'hFFFF_FFF8, 48'h2, 64'h3, 64'h4);
      send_item(KIND_QUERY,  32'hFFFF_FFF8, 48'd0, 64'd0, 64'd0);
      req_tvalid <= 1'b0;
   endtask

   // Mostly notes and queries over a small station pool with slowly advancing
   // time, plus removes, rare clears and fully random noise.
   task automatic random_burst(input int n_items, input int pool_n, input int step_max);
      logic [47:0] pool_mac [24];
      logic [63:0] pool_uhi [24];
      logic [63:0] pool_ulo [24];
      logic [63:0] r64;
      int          j;
      int          sel;
      int          r;
      for (j = 0; j < pool_n; j++) begin
         r64 = rand64();
         pool_mac[j] = r64[47:0];
         if (j > 0 && $urandom_range(0, 3) == 0)
            pool_mac[j] = pool_mac[j-1];
         pool_uhi[j] = rand64();
         pool_ulo[j] = rand64();
      end
      for (j = 0; j < n_items; j++) begin
         sel = $urandom_range(0, pool_n - 1);
         r   = $urandom_range(0, 99);
         if ($urandom_range(0, 99) < 3)
            now_t = $urandom();
         else
            now_t = now_t + $urandom_range(0, step_max);
         r64 = rand64();
         if (r < 48) begin
            if ($urandom_range(0, 99) < 8)
               send_item(KIND_NOTE, now_t, r64[47:0], rand64(), rand64());
            else
               send_item(KIND_NOTE, now_t, pool_mac[sel], pool_uhi[sel], pool_ulo[sel]);
         end else if (r < 78) begin
            send_item(KIND_QUERY, now_t, r64[47:0], rand64(), rand64());
         end else if (r < 92) begin
            if ($urandom_range(0, 4) == 0)
               send_item(KIND_REMOVE, now_t, r64[47:0], rand64(), rand64());
            else
               send_item(KIND_REMOVE, now_t, pool_mac[sel], rand64(), rand64());
         end else if (r < 98) begin
            send_item(kind_type'($urandom_range(0, 3)), $urandom(), r64[47:0],
                      rand64(), rand64());
         end else begin
            send_item(KIND_CLEAR, now_t, r64[47:0], rand64(), rand64());
         end
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int p;
      int w;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed_items();

      for (p = 0; p < PHASES; p++) begin
         w = (phase_window[p] < 0) ? $urandom_range(0, 65535) : phase_window[p];
         set_window(w[WINDOW_W-1:0]);
         windows_used++;
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         if (p % 3 == 1)
            now_t = 32'hFFFF_FFFF - $urandom_range(0, 3 * w + 20);
         else
            now_t = $urandom();
         random_burst(PHASE_ITEMS, phase_pool[p], w / 6 + 1);
      end

      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("run covered %0d tracker items and %0d overlap reports under %0d window settings",
               items_seen, reports_seen, windows_used);
      $display("idling phases: none, sender only, receiver only, both; %0d mismatches", errors);
      if (errors == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

>>> filelist.f
rtl/pbst_pkg.sv
rtl/push_button_session_tracker.sv
rtl/pbst_checker.sv
tb/pbst_checker.sv
tb/tb_top.sv
